/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Labeled property check on the rising edge of clk, off while rst is high.
`define VESB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vesb assertion failed");

// Same-cycle implication form.
`define VESB_ASSERT_IMP(lbl, ante, cons) \
  `VESB_ASSERT(lbl, (ante) |-> (cons))

`endif

/* rtl/vesb_pkg.sv */
// ----------------------------------------------------------------------------
// vesb_pkg
// Types, constants and helpers shared by the escape sequence builder.
// ----------------------------------------------------------------------------
package vesb_pkg;

  // Sizing
  localparam int MAX_PARAMS   = 4;
  localparam int MAX_ATTRS    = 2;
  localparam int DIGITS_MAX   = 5;
  localparam int PARAM_FIELDS = 4;
  localparam int ATTR_FIELDS  = 2;
  localparam int PARAM_LIM    = (MAX_PARAMS < PARAM_FIELDS) ? MAX_PARAMS : PARAM_FIELDS;
  localparam int ATTR_LIM     = (MAX_ATTRS < ATTR_FIELDS) ? MAX_ATTRS : ATTR_FIELDS;
  localparam int PCNT_W       = 3;
  localparam int ACNT_W       = 2;
  localparam int POS_W        = 3;

  // Byte codes
  localparam logic [7:0] BYTE_ESC  = 8'h1B;
  localparam logic [7:0] BYTE_CSI  = 8'h5B;
  localparam logic [7:0] BYTE_SEP  = 8'h3B;
  localparam logic [7:0] BYTE_ZERO = 8'h30;

  // Action codes
  localparam logic [2:0] ACT_PRINT   = 3'd0;
  localparam logic [2:0] ACT_EXECUTE = 3'd1;
  localparam logic [2:0] ACT_ESC     = 3'd2;
  localparam logic [2:0] ACT_CSI     = 3'd3;

  // Input transaction
  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         final_char;
    logic [2:0]         param_count;
    logic signed [15:0] param_0;
    logic signed [15:0] param_1;
    logic signed [15:0] param_2;
    logic signed [15:0] param_3;
    logic [1:0]         attr_count;
    logic [7:0]         attr_0;
    logic [7:0]         attr_1;
  } vesb_item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } vesb_result_t;

  // Output byte source
  typedef enum logic [2:0] {
    SEL_ESC,
    SEL_CSI,
    SEL_SEP,
    SEL_CHAR,
    SEL_DIGIT,
    SEL_ATTR
  } vesb_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load_item;
    logic      load_param;
    logic      inc_param;
    logic      digit_step;
    logic      inc_attr;
    logic      emit;
    logic      last;
    vesb_sel_t sel;
  } vesb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic new_char;
    logic new_esc;
    logic new_csi;
    logic cur_esc;
    logic pcnt_zero;
    logic acnt_zero;
    logic param_neg;
    logic param_more;
    logic attr_last;
    logic pos_zero;
    logic digit_show;
  } vesb_status_t;

  // Decimal place weight
  function automatic logic [13:0] pow10(input logic [POS_W-1:0] pos);
    logic [13:0] w;
    case (pos)
      3'd0:    w = 14'd1;
      3'd1:    w = 14'd10;
      3'd2:    w = 14'd100;
      3'd3:    w = 14'd1000;
      3'd4:    w = 14'd10000;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

endpackage

/* rtl/vt_escape_sequence_builder.sv */
// ----------------------------------------------------------------------------
// vt_escape_sequence_builder
// Serializes one terminal token into its byte sequence, one byte per strobe.
//
// A token is taken when start is high and busy is low. Its bytes come out on
// result, each marked by a one-cycle strobe, with last_byte set on the final
// byte; the receiver must take every byte as it comes. Busy stays high while
// the sequencer steps through the token: a print or execute token gives its
// character alone, an ESC dispatch the ESC byte, the final character and the
// attribute bytes, and a CSI dispatch ESC, the CSI byte, the parameters with
// separators, the attribute bytes and the final character. The digit unit
// produces one decimal place per cycle, most significant first, so each
// non-negative parameter is stepped through all five places whether or not
// its leading zeros are sent. Ignored actions leave busy low and give no result.
// ----------------------------------------------------------------------------
module vt_escape_sequence_builder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  vesb_pkg::vesb_item_t   item,
  output logic                   busy,
  output logic                   strobe,
  output vesb_pkg::vesb_result_t result
);
  import vesb_pkg::*;

  vesb_cmd_t    cmd;
  vesb_status_t status;

  // Sequencer
  vesb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Token storage, digit unit and result register
  vesb_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .strobe (strobe),
    .result (result)
  );

endmodule

/* rtl/vesb_datapath.sv */
// ----------------------------------------------------------------------------
// vesb_datapath
// Token registers, counters, MSD-first decimal digit unit and output register.
// ----------------------------------------------------------------------------
module vesb_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  vesb_pkg::vesb_item_t  item,
  input  vesb_pkg::vesb_cmd_t   cmd,
  output vesb_pkg::vesb_status_t status,
  output logic                  strobe,
  output vesb_pkg::vesb_result_t result
);
  import vesb_pkg::*;

  // Latched token
  logic [7:0]        ch;
  logic [15:0]       p0, p1, p2, p3;
  logic [7:0]        a0, a1;
  logic              cur_esc;
  logic [PCNT_W-1:0] pcnt;
  logic [ACNT_W-1:0] acnt;

  // Walk state
  logic [PCNT_W-1:0] pidx;
  logic [ACNT_W-1:0] aidx;
  logic [15:0]       val;
  logic [POS_W-1:0]  pos;
  logic              started;

  // Digit unit
  logic [13:0] weight;
  logic [16:0] thr;
  logic [16:0] sub;
  logic [3:0]  dig;
  logic [14:0] rem;
  logic [15:0] param_sel;
  logic [7:0]  attr_sel;
  logic [7:0]  byte_sel;

  // Saturated counts of the incoming token
  logic [PCNT_W-1:0] pcnt_in;
  logic [ACNT_W-1:0] acnt_in;

  always_comb begin
    pcnt_in = (item.param_count > PCNT_W'(PARAM_LIM)) ? PCNT_W'(PARAM_LIM) : item.param_count;
    acnt_in = (item.attr_count > ACNT_W'(ATTR_LIM)) ? ACNT_W'(ATTR_LIM) : item.attr_count;
  end

  // Parameter and attribute select
  always_comb begin
    case (pidx[1:0])
      2'd0:    param_sel = p0;
      2'd1:    param_sel = p1;
      2'd2:    param_sel = p2;
      2'd3:    param_sel = p3;
      default: param_sel = p0;
    endcase
    attr_sel = aidx[0] ? a1 : a0;
  end

  // One decimal digit per step: largest k with k*weight <= val
  always_comb begin
    weight = pow10(pos);
    dig    = 4'd0;
    sub    = 17'd0;
    thr    = 17'd0;
    for (int k = 1; k <= 9; k++) begin
      thr = 17'(k) * {3'b000, weight};
      if ({2'b00, val[14:0]} >= thr) begin
        dig = 4'(k);
        sub = thr;
      end
    end
    rem = val[14:0] - sub[14:0];
  end

  // Status back to the controller
  always_comb begin
    status.new_char   = (item.action == ACT_PRINT) || (item.action == ACT_EXECUTE);
    status.new_esc    = (item.action == ACT_ESC);
    status.new_csi    = (item.action == ACT_CSI);
    status.cur_esc    = cur_esc;
    status.pcnt_zero  = (pcnt == '0);
    status.acnt_zero  = (acnt == '0);
    status.param_neg  = val[15];
    status.param_more = ({1'b0, pidx} + 4'd1) < {1'b0, pcnt};
    status.attr_last  = (aidx == ACNT_W'(acnt - 2'd1));
    status.pos_zero   = (pos == '0);
    status.digit_show = started || (dig != 4'd0) || (pos == '0);
  end

  // Token capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      ch      <= item.final_char;
      p0      <= item.param_0;
      p1      <= item.param_1;
      p2      <= item.param_2;
      p3      <= item.param_3;
      a0      <= item.attr_0;
      a1      <= item.attr_1;
      cur_esc <= (item.action == ACT_ESC);
      pcnt    <= pcnt_in;
      acnt    <= acnt_in;
    end
  end

  // Counters and digit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pidx <= '0;
      aidx <= '0;
    end else if (cmd.load_item) begin
      pidx <= '0;
      aidx <= '0;
    end else begin
      if (cmd.inc_param) pidx <= pidx + 1'b1;
      if (cmd.inc_attr)  aidx <= aidx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_param) begin
      val     <= param_sel;
      pos     <= POS_W'(DIGITS_MAX - 1);
      started <= 1'b0;
    end else if (cmd.digit_step) begin
      val     <= {1'b0, rem};
      pos     <= pos - 1'b1;
      started <= started || (dig != 4'd0);
    end
  end

  // Output byte mux
  always_comb begin
    case (cmd.sel)
      SEL_ESC:   byte_sel = BYTE_ESC;
      SEL_CSI:   byte_sel = BYTE_CSI;
      SEL_SEP:   byte_sel = BYTE_SEP;
      SEL_CHAR:  byte_sel = ch;
      SEL_DIGIT: byte_sel = BYTE_ZERO + {4'd0, dig};
      SEL_ATTR:  byte_sel = attr_sel;
      default:   byte_sel = ch;
    endcase
  end

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.out_byte  <= byte_sel;
      result.last_byte <= cmd.last;
    end
  end

endmodule

/* rtl/vesb_ctrl.sv */
// ----------------------------------------------------------------------------
// vesb_ctrl
// Sequencer that walks a token's byte layout and drives the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vesb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  vesb_pkg::vesb_status_t status,
  output vesb_pkg::vesb_cmd_t    cmd,
  output logic                   busy
);
  import vesb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ESC    = 7'b0000010,
    S_SECOND = 7'b0000100,
    S_DIGIT  = 7'b0001000,
    S_SEP    = 7'b0010000,
    S_ATTR   = 7'b0100000,
    S_FINAL  = 7'b1000000
  } vesb_state_t;

  vesb_state_t state, state_next;

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd.load_item  = 1'b0;
    cmd.load_param = 1'b0;
    cmd.inc_param  = 1'b0;
    cmd.digit_step = 1'b0;
    cmd.inc_attr   = 1'b0;
    cmd.emit       = 1'b0;
    cmd.last       = 1'b0;
    cmd.sel        = SEL_CHAR;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          if (status.new_char) begin
            state_next = S_FINAL;
          end else if (status.new_esc || status.new_csi) begin
            state_next = S_ESC;
          end
        end
      end
      S_ESC: begin
        cmd.emit   = 1'b1;
        cmd.sel    = SEL_ESC;
        state_next = S_SECOND;
      end
      S_SECOND: begin
        cmd.emit = 1'b1;
        if (status.cur_esc) begin
          cmd.sel    = SEL_CHAR;
          cmd.last   = status.acnt_zero;
          state_next = status.acnt_zero ? S_IDLE : S_ATTR;
        end else begin
          cmd.sel = SEL_CSI;
          if (!status.pcnt_zero) begin
            cmd.load_param = 1'b1;
            state_next     = S_DIGIT;
          end else begin
            state_next = status.acnt_zero ? S_FINAL : S_ATTR;
          end
        end
      end
      S_DIGIT: begin
        // negative parameter emits nothing; leading zeros are skipped
        cmd.sel        = SEL_DIGIT;
        cmd.digit_step = !status.param_neg;
        cmd.emit       = !status.param_neg && status.digit_show;
        if (status.param_neg || status.pos_zero) begin
          if (status.param_more) begin
            cmd.inc_param = 1'b1;
            state_next    = S_SEP;
          end else begin
            state_next = status.acnt_zero ? S_FINAL : S_ATTR;
          end
        end
      end
      S_SEP: begin
        cmd.emit       = 1'b1;
        cmd.sel        = SEL_SEP;
        cmd.load_param = 1'b1;
        state_next     = S_DIGIT;
      end
      S_ATTR: begin
        cmd.emit     = 1'b1;
        cmd.sel      = SEL_ATTR;
        cmd.inc_attr = 1'b1;
        cmd.last     = status.cur_esc && status.attr_last;
        if (status.attr_last) begin
          state_next = status.cur_esc ? S_IDLE : S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.emit   = 1'b1;
        cmd.sel    = SEL_CHAR;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A last byte always closes the transaction
  `VESB_ASSERT(a_last_ends_token, (cmd.emit && cmd.last) |=> (state == S_IDLE))
  // An accepted escape token starts with the ESC byte
  `VESB_ASSERT(a_escape_opens, (start && !busy && (status.new_esc || status.new_csi)) |=> (state == S_ESC))
  // Digit loop leaves after the units place
  `VESB_ASSERT(a_digit_bounded, (state == S_DIGIT && status.pos_zero) |=> (state != S_DIGIT))

endmodule

/* tb/vt_escape_sequence_builder_test.sv */
// ----------------------------------------------------------------------------
// vt_escape_sequence_builder_test
// Self-checking bench for the escape sequence builder. A directed set of
// tokens covers field extremes, every action and the digit, separator and
// saturation corner cases; random tokens follow. Start is driven with random
// gaps, every strobed byte is checked against a predicted byte stream.
// ----------------------------------------------------------------------------
module vt_escape_sequence_builder_test;
  import vesb_pkg::*;

  // Actions that produce no bytes
  localparam logic [2:0] ACT_IGNORED = 3'd4;
  localparam logic [2:0] ACT_MAX     = 3'd7;

  localparam int RANDOM_TOKENS = 420;
  localparam int TAIL_CYCLES   = 40;
  localparam int REPORT_CAP    = 50;

  logic         clk;
  logic         rst;
  logic         start = 1'b0;
  vesb_item_t   item  = '0;
  logic         busy;
  logic         strobe;
  vesb_result_t result;

  vesb_item_t   pending_tokens[$];
  vesb_result_t expected_bytes[$];
  int           error_count = 0;
  int           gap_left    = 0;
  int           burst_left  = 0;
  logic [95:0]  idle_noise;

  vt_escape_sequence_builder dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic vesb_item_t make_token(
    input logic [2:0] act, input logic [7:0] ch, input logic [2:0] pcnt,
    input logic [15:0] p0, input logic [15:0] p1, input logic [15:0] p2,
    input logic [15:0] p3, input logic [1:0] acnt, input logic [7:0] a0,
    input logic [7:0] a1);
    vesb_item_t tok;
    tok.action      = act;
    tok.final_char  = ch;
    tok.param_count = pcnt;
    tok.param_0     = p0;
    tok.param_1     = p1;
    tok.param_2     = p2;
    tok.param_3     = p3;
    tok.attr_count  = acnt;
    tok.attr_0      = a0;
    tok.attr_1      = a1;
    return tok;
  endfunction

  // Parameter mix: zero, each digit length, negatives and raw bits
  function automatic logic [15:0] rand_param();
    logic [15:0] p;
    case ($urandom_range(0, 5))
      0:       p = 16'd0;
      1:       p = 16'($urandom_range(1, 9));
      2:       p = 16'($urandom_range(10, 999));
      3:       p = 16'($urandom_range(1000, 32767));
      4:       p = 16'($urandom_range(32768, 65535));
      default: p = 16'($urandom);
    endcase
    return p;
  endfunction

  // Byte stream of one token, appended to the expected stream
  function automatic void predict_token_bytes(input vesb_item_t tok);
    logic [7:0]  seq[$];
    logic [7:0]  digs[$];
    logic [15:0] prm[PARAM_FIELDS];
    logic [7:0]  atr[ATTR_FIELDS];
    int          pcnt;
    int          acnt;
    int          v;
    vesb_result_t r;
    prm  = '{tok.param_0, tok.param_1, tok.param_2, tok.param_3};
    atr  = '{tok.attr_0, tok.attr_1};
    pcnt = (tok.param_count > PARAM_LIM) ? PARAM_LIM : int'(tok.param_count);
    acnt = (tok.attr_count > ATTR_LIM) ? ATTR_LIM : int'(tok.attr_count);
    case (tok.action)
      ACT_PRINT, ACT_EXECUTE: begin
        seq.push_back(tok.final_char);
      end
      ACT_ESC: begin
        seq.push_back(BYTE_ESC);
        seq.push_back(tok.final_char);
        for (int i = 0; i < acnt; i++) seq.push_back(atr[i]);
      end
      ACT_CSI: begin
        seq.push_back(BYTE_ESC);
        seq.push_back(BYTE_CSI);
        for (int i = 0; i < pcnt; i++) begin
          if (i > 0) seq.push_back(BYTE_SEP);
          // negative parameter keeps only its separator
          if (!prm[i][15]) begin
            digs.delete();
            v = int'(prm[i]);
            do begin
              digs.push_front(BYTE_ZERO + 8'(v % 10));
              v = v / 10;
            end while (v > 0);
            foreach (digs[k]) seq.push_back(digs[k]);
          end
        end
        for (int i = 0; i < acnt; i++) seq.push_back(atr[i]);
        seq.push_back(tok.final_char);
      end
      default: ;
    endcase
    foreach (seq[k]) begin
      r.out_byte  = seq[k];
      r.last_byte = (k == seq.size() - 1);
      expected_bytes.push_back(r);
    end
  endfunction

  // Driver: launches queued tokens after a random gap, holds while busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        // previous transaction accepted: pick the gap before the next one
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 19) == 0) begin
          burst_left = $urandom_range(5, 20);
          gap_left   = 0;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap_left = 0;
            5, 6, 7, 8:    gap_left = $urandom_range(1, 4);
            default:       gap_left = $urandom_range(8, 40);
          endcase
        end
      end
      if (gap_left == 0 && pending_tokens.size() > 0) begin
        item  <= pending_tokens.pop_front();
        start <= 1'b1;
      end else begin
        if (gap_left > 0) gap_left--;
        idle_noise = {$urandom, $urandom, $urandom};
        item  <= idle_noise[$bits(vesb_item_t)-1:0];
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts on accepted transactions, checks every strobed byte
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) predict_token_bytes(item);
      if (strobe) begin
        if (expected_bytes.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_CAP)
            $display("%0t: unexpected byte: expected none, actual %h last %b",
                     $time, result.out_byte, result.last_byte);
        end else begin
          if (result.out_byte !== expected_bytes[0].out_byte ||
              result.last_byte !== expected_bytes[0].last_byte) begin
            error_count++;
            if (error_count <= REPORT_CAP)
              $display("%0t: byte mismatch: expected %h last %b, actual %h last %b",
                       $time, expected_bytes[0].out_byte, expected_bytes[0].last_byte,
                       result.out_byte, result.last_byte);
          end
          void'(expected_bytes.pop_front());
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int          produced;
    logic [2:0]  act;
    logic [2:0]  pcnt;
    int          sel;

    // print at character extremes, execute with every field but the character at its maximum
    pending_tokens.push_back(make_token(ACT_PRINT, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tokens.push_back(make_token(ACT_PRINT, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tokens.push_back(make_token(ACT_EXECUTE, 8'h0A, 7, 16'hFFFF, 16'hFFFF,
                                        16'hFFFF, 16'hFFFF, 3, 8'hFF, 8'hFF));
    // ESC dispatch with every attribute count, including saturation
    for (int a = 0; a < 4; a++)
      pending_tokens.push_back(make_token(ACT_ESC, 8'h63, 0, 0, 0, 0, 0, 2'(a),
                                          8'h28, 8'hFF));
    // CSI with no parameters, a zero, and each digit length
    pending_tokens.push_back(make_token(ACT_CSI, 8'h6D, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tokens.push_back(make_token(ACT_CSI, 8'h48, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_tokens.push_back(make_token(ACT_CSI, 8'h48, 4, 1, 99, 100, 999, 0, 0, 0));
    pending_tokens.push_back(make_token(ACT_CSI, 8'h48, 4, 1000, 9999, 10000, 32767,
                                        0, 0, 0));
    // negative parameters keep their separators
    pending_tokens.push_back(make_token(ACT_CSI, 8'h72, 3, 16'hFFFF, 5, 16'h8000, 0,
                                        0, 0, 0));
    pending_tokens.push_back(make_token(ACT_CSI, 8'h72, 4, 16'h8000, 16'hFFFF,
                                        16'hFFFF, 16'h8000, 1, 8'h3F, 0));
    // parameter count saturation
    for (int c = 5; c < 8; c++)
      pending_tokens.push_back(make_token(ACT_CSI, 8'h6D, 3'(c), 12345, 7, 0, 42,
                                          2'(c - 5), 8'h20, 8'h21));
    // longest token: four five-digit parameters and both attributes
    pending_tokens.push_back(make_token(ACT_CSI, 8'hFF, 4, 32767, 32767, 32767,
                                        32767, 2, 8'h00, 8'hFF));
    pending_tokens.push_back(make_token(ACT_CSI, 8'h00, 4, 16'h7FFF, 16'h8000,
                                        0, 16'h7FFF, 3, 8'hFF, 8'h00));
    // ignored actions
    for (int a = ACT_IGNORED; a <= ACT_MAX; a++)
      pending_tokens.push_back(make_token(3'(a), 8'h41, 4, 1, 2, 3, 4, 2, 8'h20,
                                          8'h21));

    // random tokens, ignored actions mixed in
    produced = 0;
    while (produced < RANDOM_TOKENS) begin
      sel = $urandom_range(0, 99);
      if (sel < 10)      act = ACT_PRINT;
      else if (sel < 20) act = ACT_EXECUTE;
      else if (sel < 40) act = ACT_ESC;
      else if (sel < 88) act = ACT_CSI;
      else               act = 3'($urandom_range(ACT_IGNORED, ACT_MAX));
      pcnt = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                          : 3'($urandom_range(5, 7));
      pending_tokens.push_back(make_token(act, 8'($urandom), pcnt, rand_param(),
                                          rand_param(), rand_param(), rand_param(),
                                          2'($urandom), 8'($urandom), 8'($urandom)));
      produced++;
    end

    // wait for every transaction to be taken and every byte to arrive
    @(posedge clk);
    while (pending_tokens.size() != 0 || start) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (expected_bytes.size() != 0)
        $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
